// File: hdl/subset_sum_residue_counter_defines.svh
// Assertion macros for the port-level checker of the subset-sum residue counter.
`ifndef SUBSET_SUM_RESIDUE_COUNTER_DEFINES_SVH
`define SUBSET_SUM_RESIDUE_COUNTER_DEFINES_SVH

// Property checked on every rising edge, ignored while reset is held.
`define SSRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define SSRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/sscr_pkg.sv
// Types and constants shared by the subset-sum residue counter modules.
`timescale 1ns / 1ps

package sscr_pkg;

  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 30;
  localparam int MODULUS_W   = 8;
  localparam int OUT_TDATA_W = 32;

  // Counts are kept modulo this prime; the sum of two counts needs one more bit.
  localparam logic [COUNT_W:0] COUNT_PRIME = 31'd1000000009;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // item accepted: start residue, rewind sweep index
    logic sweep;    // issue one table entry this cycle
    logic finish;   // sweep done: swap banks
    logic restore;  // with finish: next sweep reads the table as freshly reset
    logic emit;     // move the captured residue-zero count to the output register
  } sscr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;   // residue of the value is ready
    logic sweep_end;  // last table entry is being issued
  } sscr_sts_t;

endpackage

// File: hdl/subset_sum_residue_counter.sv
// A new item is taken only after the previous one is through: the 32-step bit-serial
//   remainder, then the sweep at one table entry per cycle through the memory; a last
//   item also waits until the output register is free to take its result.
// A result waiting in the output register does not block the next item.
// Reset (rst_n low, synchronous): modulus 1, table reads as one at residue zero, no result.
`timescale 1ns / 1ps

module subset_sum_residue_counter #(
  parameter int MAX_MODULUS = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration: modulus
  input  logic                              cfg_wr_en,
  input  logic [sscr_pkg::MODULUS_W-1:0]    cfg_wr_data,
  // input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sscr_pkg::VALUE_W-1:0]      in_tdata,   // [31:0] value (signed)
  input  logic                              in_tlast,   // last
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sscr_pkg::OUT_TDATA_W-1:0]  out_tdata   // [29:0] subset_count, [31:30] zero
);

  import sscr_pkg::*;

  sscr_cmd_t          cmd;
  sscr_sts_t          sts;
  logic [COUNT_W-1:0] out_count;

  sscr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  sscr_datapath #(
    .MAX_MODULUS (MAX_MODULUS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_value    (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_count   (out_count)
  );

  assign out_tdata = {{(OUT_TDATA_W - COUNT_W){1'b0}}, out_count};

endmodule

// File: hdl/sscr_residue.sv
// Bit-serial signed remainder: value mod modulus reduced into 0 .. modulus-1.
`timescale 1ns / 1ps

module sscr_residue #(
  parameter int AW = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sscr_pkg::VALUE_W-1:0] value,
  input  logic [AW:0]                modulus,
  output logic                       done,
  output logic [AW-1:0]              residue
);

  import sscr_pkg::*;

  localparam int SW = $clog2(VALUE_W);

  logic [VALUE_W-1:0] mag_r;
  logic [AW-1:0]      rem_r;
  logic [AW-1:0]      rem_nxt;
  logic               neg_r;
  logic               busy_r;
  logic               done_r;
  logic [SW-1:0]      step_r;
  logic [AW:0]        trial;
  logic [AW:0]        trial_diff;
  logic [AW:0]        wrap;

  // Shift in the next magnitude bit and subtract the modulus if it fits
  always_comb begin
    trial      = {rem_r, mag_r[VALUE_W-1]};
    trial_diff = trial - modulus;
    rem_nxt    = (trial >= modulus) ? trial_diff[AW-1:0] : trial[AW-1:0];
  end

  // Control: count one step per magnitude bit, pulse done after the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == SW'(VALUE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: magnitude shift register and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= value[VALUE_W-1];
      mag_r <= value[VALUE_W-1] ? (~value + 1'b1) : value;
      rem_r <= '0;
    end else if (busy_r) begin
      mag_r <= {mag_r[VALUE_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  // Fold a negative remainder back into range
  assign wrap    = modulus - {1'b0, rem_r};
  assign residue = (neg_r && (rem_r != '0)) ? wrap[AW-1:0] : rem_r;
  assign done    = done_r;

endmodule

// File: hdl/sscr_datapath.sv
// Datapath: modulus register, residue unit, two-bank count table and modular adder.
`timescale 1ns / 1ps

module sscr_datapath #(
  parameter int MAX_MODULUS = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [sscr_pkg::MODULUS_W-1:0]  cfg_wr_data,
  input  logic [sscr_pkg::VALUE_W-1:0]    in_value,
  input  sscr_pkg::sscr_cmd_t             cmd,
  output sscr_pkg::sscr_sts_t             sts,
  output logic [sscr_pkg::COUNT_W-1:0]    out_count
);

  import sscr_pkg::*;

  localparam int AW    = $clog2(MAX_MODULUS);
  localparam int MW    = AW + 1;
  localparam int CW    = (MW > MODULUS_W) ? MW : MODULUS_W;
  localparam int DEPTH = 2 ** MW;

  logic [MW-1:0]      m_r;
  logic [MW-1:0]      m_nxt;
  logic [CW-1:0]      cfg_ext;
  logic               res_done;
  logic [AW-1:0]      res_val;
  logic [AW-1:0]      r_r;
  logic [AW-1:0]      j_r;
  logic               bank_r;
  logic               fresh_r;
  logic               in_range;
  logic [AW:0]        diff;
  logic [AW:0]        diff_wrap;
  logic [AW-1:0]      src;
  logic [COUNT_W-1:0] mem [DEPTH];
  logic [COUNT_W-1:0] rd_a_r;
  logic [COUNT_W-1:0] rd_b_r;
  logic               p1_valid_r;
  logic [AW:0]        p1_waddr_r;
  logic               p1_fresh_r;
  logic               p1_in_range_r;
  logic               p1_j_zero_r;
  logic               p1_src_zero_r;
  logic [COUNT_W-1:0] add_a;
  logic [COUNT_W-1:0] add_b;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W:0]   sum_red;
  logic [COUNT_W-1:0] wdata;
  logic [COUNT_W-1:0] cnt0_r;
  logic [COUNT_W-1:0] out_count_r;

  // Clamp the written modulus to 1 .. MAX_MODULUS
  always_comb begin
    cfg_ext = CW'(cfg_wr_data);
    if (cfg_ext == '0) begin
      m_nxt = MW'(1);
    end else if (cfg_ext > CW'(MAX_MODULUS)) begin
      m_nxt = MW'(MAX_MODULUS);
    end else begin
      m_nxt = cfg_ext[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= MW'(1);
    end else if (cfg_wr_en) begin
      m_r <= m_nxt;
    end
  end

  sscr_residue #(
    .AW (AW)
  ) u_residue (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.load),
    .value   (in_value),
    .modulus (m_r),
    .done    (res_done),
    .residue (res_val)
  );

  // Hold the residue and step the sweep index
  always_ff @(posedge clk) begin
    if (res_done) begin
      r_r <= res_val;
    end
    if (cmd.load) begin
      j_r <= '0;
    end else if (cmd.sweep) begin
      j_r <= j_r + 1'b1;
    end
  end

  // Bank select and fresh-table flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r  <= 1'b0;
      fresh_r <= 1'b1;
    end else if (cmd.finish) begin
      bank_r  <= ~bank_r;
      fresh_r <= cmd.restore;
    end
  end

  // Source entry (j - r) mod m; entries at or above m are copied unchanged
  always_comb begin
    in_range  = ({1'b0, j_r} < m_r);
    diff      = {1'b0, j_r} - {1'b0, r_r};
    diff_wrap = diff + m_r;
    if (!in_range) begin
      src = j_r;
    end else if (diff[AW]) begin
      src = diff_wrap[AW-1:0];
    end else begin
      src = diff[AW-1:0];
    end
  end

  // Read both old counts from the current bank
  always_ff @(posedge clk) begin
    rd_a_r <= mem[{bank_r, j_r}];
    rd_b_r <= mem[{bank_r, src}];
  end

  // Carry the write address and flags alongside the read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= cmd.sweep;
    end
  end

  always_ff @(posedge clk) begin
    p1_waddr_r    <= {~bank_r, j_r};
    p1_fresh_r    <= fresh_r;
    p1_in_range_r <= in_range;
    p1_j_zero_r   <= (j_r == '0);
    p1_src_zero_r <= (src == '0);
  end

  // Modular add; a fresh table reads as one at entry zero and zero elsewhere
  always_comb begin
    if (p1_fresh_r) begin
      add_a = p1_j_zero_r ? COUNT_W'(1) : '0;
    end else begin
      add_a = rd_a_r;
    end
    if (!p1_in_range_r) begin
      add_b = '0;
    end else if (p1_fresh_r) begin
      add_b = p1_src_zero_r ? COUNT_W'(1) : '0;
    end else begin
      add_b = rd_b_r;
    end
    sum     = {1'b0, add_a} + {1'b0, add_b};
    sum_red = (sum >= COUNT_PRIME) ? (sum - COUNT_PRIME) : sum;
    wdata   = sum_red[COUNT_W-1:0];
  end

  // Write the new count into the other bank
  always_ff @(posedge clk) begin
    if (p1_valid_r) begin
      mem[p1_waddr_r] <= wdata;
    end
  end

  // Capture the new residue-zero count, then hand it to the output register
  always_ff @(posedge clk) begin
    if (p1_valid_r && p1_j_zero_r) begin
      cnt0_r <= wdata;
    end
    if (cmd.emit) begin
      out_count_r <= cnt0_r;
    end
  end

  assign sts.div_done  = res_done;
  assign sts.sweep_end = (j_r == AW'(MAX_MODULUS - 1));
  assign out_count     = out_count_r;

endmodule

// File: hdl/sscr_ctrl.sv
// Controller: item handshake, sequencing of residue and sweep, result register valid.
`timescale 1ns / 1ps

module sscr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tlast,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output sscr_pkg::sscr_cmd_t cmd,
  input  sscr_pkg::sscr_sts_t sts
);

  import sscr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SWEEP,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   last_r;
  logic   last_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;
  logic   slot_free;

  assign accept    = in_tvalid && (state_r == ST_IDLE);
  assign slot_free = !out_valid_r || out_tready;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          last_nxt  = in_tlast;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_end) begin
          cmd.finish  = 1'b1;
          cmd.restore = last_r;
          state_nxt   = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// File: hdl/sscr_checker.sv
// Port-level checker for the subset-sum residue counter, bound to the top level.
`timescale 1ns / 1ps
`include "subset_sum_residue_counter_defines.svh"

module sscr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [sscr_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  import sscr_pkg::*;

  // Stalled result holds
  `SSRC_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // Counts stay below the prime and the padding stays zero
  `SSRC_ASSERT(a_out_range, out_tvalid |-> out_tdata < OUT_TDATA_W'(COUNT_PRIME), "result out of range")

  // Each item is worked on alone: no item is taken right after another
  `SSRC_ASSERT(a_one_at_a_time, in_tvalid && in_tready |=> !in_tready, "item taken while busy")

  // Reset drops any pending result
  `SSRC_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind subset_sum_residue_counter sscr_checker u_sscr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/subset_sum_residue_counter_checker.sv
// Checker for the subset-sum residue counter: keeps its own residue table and compares each count.
`timescale 1ns / 1ps

module subset_sum_residue_counter_checker #(
  parameter int MAX_MODULUS = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [sscr_pkg::MODULUS_W-1:0]    cfg_wr_data,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [sscr_pkg::VALUE_W-1:0]      in_tdata,   // [31:0] value (signed)
  input  logic                              in_tlast,   // last
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [sscr_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [29:0] subset_count, [31:30] zero
  output int unsigned                       mismatches,
  output int unsigned                       counts_owed
);
  import sscr_pkg::*;

  logic [COUNT_W-1:0]   tally [MAX_MODULUS];
  logic [COUNT_W-1:0]   tally_copy [MAX_MODULUS];
  logic [MODULUS_W-1:0] modulus_q;
  logic [COUNT_W-1:0]   owed_counts [$];
  int unsigned          n_bad = 0;

  // Restore the table: only the empty subset, at residue zero
  function automatic void clear_tally();
    for (int i = 0; i < MAX_MODULUS; i++) tally[i] = '0;
    tally[0] = COUNT_W'(1);
  endfunction

  // Map zero to one and clamp large settings to the table depth
  function automatic int unsigned active_modulus();
    int unsigned m;
    m = 32'(modulus_q);
    if (m == 0) m = 1;
    if (m > MAX_MODULUS) m = MAX_MODULUS;
    return m;
  endfunction

  // Signed remainder, pulled up into 0..m-1
  function automatic int unsigned residue_of_value(logic [VALUE_W-1:0] v, int unsigned m);
    longint sv;
    longint r;
    sv = longint'($signed(v));
    r = sv % longint'(m);
    if (r < 0) r += longint'(m);
    return 32'(r);
  endfunction

  // Add the table rotated by the value's residue onto itself, modulo the prime
  function automatic void fold_value(logic [VALUE_W-1:0] v);
    int unsigned m;
    int unsigned r;
    int unsigned c;
    logic [COUNT_W:0] sum;
    m = active_modulus();
    r = residue_of_value(v, m);
    for (int l = 0; l < m; l++) tally_copy[l] = tally[l];
    for (int l = 0; l < m; l++) begin
      c = l + r;
      if (c >= m) c -= m;
      sum = {1'b0, tally[c]} + {1'b0, tally_copy[l]};
      if (sum >= COUNT_PRIME) sum -= COUNT_PRIME;
      tally[c] = sum[COUNT_W-1:0];
    end
  endfunction

  always @(posedge clk) begin
    logic [COUNT_W-1:0] want;
    if (!rst_n) begin
      modulus_q = MODULUS_W'(1);
      clear_tally();
      owed_counts.delete();
    end else begin
      if (cfg_wr_en) modulus_q = cfg_wr_data;
      // Fold each accepted item; a closing item owes the residue-zero count
      if (in_tvalid && in_tready) begin
        fold_value(in_tdata);
        if (in_tlast) begin
          owed_counts = {owed_counts, tally[0]};
          clear_tally();
        end
      end
      // Compare each delivered count with the oldest one owed
      if (out_tvalid && out_tready) begin
        if (owed_counts.size() == 0) begin
          n_bad++;
          $display("%0t: subset_count expected none, got %0d", $time,
                   out_tdata[COUNT_W-1:0]);
        end else begin
          want = owed_counts.pop_front();
          if (out_tdata[COUNT_W-1:0] !== want) begin
            n_bad++;
            $display("%0t: subset_count expected %0d, got %0d", $time, want,
                     out_tdata[COUNT_W-1:0]);
          end
        end
      end
    end
    mismatches  <= n_bad;
    counts_owed <= owed_counts.size();
  end

endmodule

// File: tb/subset_sum_residue_counter_tb.sv
// Testbench top for the subset-sum residue counter: drives items and modulus, gives the verdict.
`timescale 1ns / 1ps

module subset_sum_residue_counter_tb;
  import sscr_pkg::*;

  localparam int MAX_MODULUS   = 128;
  localparam int SETTLE_CYCLES = MAX_MODULUS + 40;
  localparam int HOLD_CYCLES   = 4000;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 82;
  localparam int unsigned LIMIT = 2_000_000;

  typedef enum logic [1:0] {RX_FLOW, RX_COIN, RX_STALL} rx_mode_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [MODULUS_W-1:0]   cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [VALUE_W-1:0]     in_tdata;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int unsigned mismatches;
  int unsigned counts_owed;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned cur_modulus = 1;
  bit          offering    = 0;
  bit          hold_req    = 0;

  subset_sum_residue_counter #(
    .MAX_MODULUS (MAX_MODULUS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  subset_sum_residue_counter_checker #(
    .MAX_MODULUS (MAX_MODULUS)
  ) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .counts_owed (counts_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abandon a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("subset_sum_residue_counter_tb: errors");
      $finish;
    end
  end

  // Result side: free flow, coin-toss and stall stretches, plus one long hold on request
  initial begin
    rx_mode_t    mode;
    int unsigned mode_left;
    mode = RX_FLOW;
    mode_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = (mode == RX_STALL) ? $urandom_range(1, 40) : $urandom_range(20, 400);
        end
        mode_left--;
        case (mode)
          RX_FLOW: out_tready <= 1'b1;
          RX_COIN: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= 1'b0;
        endcase
      end
    end
  end

  // Offer one item and hold it until taken; end a burst with a random gap
  task automatic send_item(input logic [VALUE_W-1:0] value, input logic last);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    offering = 1;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 11);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 5);
        2:       gap = $urandom_range(10, 60);
        default: gap = $urandom_range(100, 170);
      endcase
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        offering = 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Withdraw the input, wait for every owed count, then let a pending fold finish
  task automatic drain();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 0;
    end
    do @(posedge clk); while (counts_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [MODULUS_W-1:0] m);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_modulus = (m == 0) ? 1 : (m > MAX_MODULUS) ? MAX_MODULUS : m;
  endtask

  // Mix of full-range, small signed, multiples of the modulus and corner values
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] corner [4];
    int k;
    corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000};
    case ($urandom_range(0, 7))
      0, 1, 2: return $urandom();
      3:       return 32'(int'($urandom_range(0, 600)) - 300);
      4: begin
        k = int'($urandom_range(0, 2000)) - 1000;
        return 32'(k * int'(cur_modulus));
      end
      5:       return corner[$urandom_range(0, 3)];
      6:       return 32'h8000_0000 | 32'($urandom_range(0, 1023));
      default: return 32'($urandom_range(0, 2 * cur_modulus));
    endcase
  endfunction

  task automatic send_run(input int unsigned len, input bit close);
    for (int i = 0; i < len; i++) send_item(pick_value(), close && (i == len - 1));
  endtask

  initial begin
    int unsigned len;
    int unsigned left;
    logic [MODULUS_W-1:0] mod_sel;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tlast    <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset modulus of one: a lone zero
    send_item(32'd0, 1'b1);
    // Full table with the value extremes
    configure(8'd128);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'd127, 1'b0);
    send_item(32'd128, 1'b1);
    // Modulus zero behaves as one
    configure(8'd0);
    send_item(32'd5, 1'b1);
    send_item(-32'sd5, 1'b1);
    // Modulus above the table depth saturates
    configure(8'd255);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b1);
    // Modulus changed part way through a sequence
    configure(8'd7);
    send_item(-32'sd1, 1'b0);
    send_item(-32'sd8, 1'b0);
    send_item(32'd13, 1'b0);
    configure(8'd3);
    send_item(32'd2, 1'b0);
    send_item(32'd1, 1'b1);

    // Random phases; a phase may leave its final sequence open across the next write
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       mod_sel = 8'd1;
        1:       mod_sel = 8'd128;
        2:       mod_sel = 8'd2;
        3:       mod_sel = 8'd0;
        4:       mod_sel = 8'($urandom_range(1, 16));
        5:       mod_sel = 8'd255;
        6:       mod_sel = 8'($urandom_range(129, 254));
        default: mod_sel = 8'($urandom_range(1, 128));
      endcase
      configure(mod_sel);
      // Starve the result side while short sequences keep arriving
      if (p == 4) begin
        hold_req = 1;
        repeat (16) send_item(pick_value(), 1'b1);
      end
      left = PHASE_ITEMS;
      while (left > 0) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
        if (len > left) len = left;
        left -= len;
        send_run(len, (left > 0) || ($urandom_range(0, 2) != 0));
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("subset_sum_residue_counter_tb: clean");
    end else begin
      $display("subset_sum_residue_counter_tb: errors");
    end
    $finish;
  end

endmodule
